// ----- hdl/scs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the 3x3 Cramer offset solver.
// Holds the widths, the saturation marker and the divider unit's constants.
// ----------------------------------------------------------------------------
package scs_pkg;
	localparam int InW = 16;
	localparam int OutW = 25;
	localparam int ProdW = 33;
	localparam int CofW = 34;
	localparam int DetW = 52;
	localparam int NumW = 52;
	localparam int LenW = 6;
	localparam int FitW = 32;
	localparam int DivW = 44;
	localparam int QuoW = 44;
	localparam int SatBits = 9;
	localparam logic [OutW-1:0] SatValue = 25'h0ffffff;

	typedef logic signed [InW-1:0] in_t;
	typedef logic signed [OutW-1:0] out_t;

	// Result class of one component on its way through the divider.
	typedef enum logic [1:0] {
		RES_DIV,
		RES_ZERO,
		RES_SAT
	} res_kind_t;

	// Bit length of a signed value: one plus the bit length of its magnitude.
	function automatic logic [LenW-1:0] bit_len(input logic signed [NumW-1:0] v);
		logic [NumW-1:0] mag;
		logic [LenW-1:0] n;
		mag = v[NumW-1] ? (~v + 1'b1) : v;
		n = LenW'(1);
		for (int i = 0; i < NumW; i++) begin
			if (mag[i]) begin
				n = LenW'(i + 2);
			end
		end
		return n;
	endfunction
endpackage
`default_nettype wire

// ----- hdl/scs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_div: pipelined signed divider, truncating toward zero.
// Restoring division, one quotient bit per stage, with an advance enable.
// ----------------------------------------------------------------------------
module scs_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic signed [scs_pkg::DivW-1:0] dividend,
	input  wire logic signed [scs_pkg::FitW-1:0] divisor,
	input  wire scs_pkg::res_kind_t            kind_in,
	output logic signed [scs_pkg::OutW-1:0]    quotient,
	output scs_pkg::res_kind_t                 kind_out
);
	import scs_pkg::*;

	localparam int Steps = QuoW;

	logic [QuoW-1:0] rem_s [Steps+1];
	logic [QuoW-1:0] quo_s [Steps+1];
	logic [FitW-1:0] dvs_s [Steps+1];
	logic            neg_s [Steps+1];
	res_kind_t       kind_s [Steps+1];
	logic [FitW:0]   part_s [Steps+1];

	// Stage zero: take magnitudes.
	always_comb begin
		quo_s[0] = dividend[DivW-1] ? QuoW'(~dividend + 1'b1) : QuoW'(dividend);
		rem_s[0] = '0;
		dvs_s[0] = divisor[FitW-1] ? (~divisor + 1'b1) : divisor;
		neg_s[0] = dividend[DivW-1] ^ divisor[FitW-1];
		kind_s[0] = kind_in;
		part_s[0] = '0;
	end

	// One quotient bit per registered stage; the partial remainder stays narrow.
	for (genvar g = 0; g < Steps; g++) begin : g_step
		logic [FitW:0] trial;
		logic [FitW+1:0] diff;
		assign trial = {part_s[g][FitW-1:0], quo_s[g][QuoW-1]};
		assign diff = {1'b0, trial} - {2'b00, dvs_s[g]};
		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[g+1] <= dvs_s[g];
				neg_s[g+1] <= neg_s[g];
				kind_s[g+1] <= kind_s[g];
				rem_s[g+1] <= rem_s[g];
				if (!diff[FitW+1]) begin
					part_s[g+1] <= diff[FitW:0];
					quo_s[g+1] <= {quo_s[g][QuoW-2:0], 1'b1};
				end else begin
					part_s[g+1] <= trial;
					quo_s[g+1] <= {quo_s[g][QuoW-2:0], 1'b0};
				end
			end
		end
	end

	// Sign fix and selection of the marker or zero.
	always_comb begin
		case (kind_s[Steps])
			RES_SAT:  quotient = SatValue;
			RES_ZERO: quotient = '0;
			default:  quotient = neg_s[Steps] ? OutW'(~quo_s[Steps] + 1'b1)
				: OutW'(quo_s[Steps]);
		endcase
		kind_out = kind_s[Steps];
	end

	logic unused_rem;
	assign unused_rem = ^rem_s[Steps] ^ arst_n;
endmodule
`default_nettype wire

// ----- hdl/symmetric3_cramer_solve_q12.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric3_cramer_solve_q12: Q12 subpixel offset by Cramer's rule.
// Solves H x = -g for a symmetric 3x3 Hessian in a deep pipeline.
// ----------------------------------------------------------------------------
// One item is accepted every cycle while the output side takes results. The
// pipeline has four product and sum stages, a bit-length stage, a saturation
// and scaling stage, 44 divider stages (one quotient bit each, set by the
// 44-bit dividend of numerator times 4096) and the output register. The whole
// pipeline advances together; when the output is stalled every stage holds,
// so nothing is lost or repeated.
module symmetric3_cramer_solve_q12 (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// hess_e0..e5, grad_a, grad_b, grad_c, 16 bits each from bit 0 up
	input  wire logic [143:0]  s_tdata,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// offset_a [24:0], offset_b [49:25], offset_c [74:50], zero fill to 80
	output logic [79:0]        m_tdata
);
	import scs_pkg::*;

	localparam int Lat = 6 + QuoW;

	logic en;
	logic [Lat-1:0] vld_q;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], s_tvalid};
			m_tvalid <= vld_q[Lat-1];
		end
	end

	in_t h0, h1, h2, h3, h4, h5, g0, g1, g2;
	assign {g2, g1, g0, h5, h4, h3, h2, h1, h0} = s_tdata;

	// Stage 1: pairwise products.
	logic signed [ProdW-1:0] p34_s1, p51_s1, p54_s1, p32_s1, p12_s1, p44_s1;
	logic signed [ProdW-1:0] p35_s1, p04_s1, p02_s1, p55_s1, p01_s1, p33_s1;
	in_t h0_s1, h3_s1, h5_s1, g0_s1, g1_s1, g2_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			p34_s1 <= h3 * h4; p51_s1 <= h5 * h1; p54_s1 <= h5 * h4;
			p32_s1 <= h3 * h2; p12_s1 <= h1 * h2; p44_s1 <= h4 * h4;
			p35_s1 <= h3 * h5; p04_s1 <= h0 * h4; p02_s1 <= h0 * h2;
			p55_s1 <= h5 * h5; p01_s1 <= h0 * h1; p33_s1 <= h3 * h3;
			h0_s1 <= h0; h3_s1 <= h3; h5_s1 <= h5;
			g0_s1 <= g0; g1_s1 <= g1; g2_s1 <= g2;
		end
	end

	// Stage 2: cofactors and minors.
	logic signed [CofW-1:0] c0_s2, c1_s2, c2_s2, mix_s2, m1_s2, m2_s2;
	in_t h0_s2, h3_s2, h5_s2, g0_s2, g1_s2, g2_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			c0_s2 <= CofW'(p34_s1) - CofW'(p51_s1);
			c1_s2 <= CofW'(p54_s1) - CofW'(p32_s1);
			c2_s2 <= CofW'(p12_s1) - CofW'(p44_s1);
			mix_s2 <= CofW'(p35_s1) - CofW'(p04_s1);
			m1_s2 <= CofW'(p02_s1) - CofW'(p55_s1);
			m2_s2 <= CofW'(p01_s1) - CofW'(p33_s1);
			h0_s2 <= h0_s1; h3_s2 <= h3_s1; h5_s2 <= h5_s1;
			g0_s2 <= g0_s1; g1_s2 <= g1_s1; g2_s2 <= g2_s1;
		end
	end

	// Stage 3: cofactor and minor times entry products.
	logic signed [NumW-1:0] d0_s3, d1_s3, d2_s3;
	logic signed [NumW-1:0] a0_s3, a1_s3, a2_s3, b0_s3, b1_s3, b2_s3;
	logic signed [NumW-1:0] e0_s3, e1_s3, e2_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			d0_s3 <= NumW'(h0_s2 * c2_s2);
			d1_s3 <= NumW'(h3_s2 * c1_s2);
			d2_s3 <= NumW'(h5_s2 * c0_s2);
			a0_s3 <= NumW'(g0_s2 * c2_s2);
			a1_s3 <= NumW'(g1_s2 * c1_s2);
			a2_s3 <= NumW'(g2_s2 * c0_s2);
			b0_s3 <= NumW'(m1_s2 * g1_s2);
			b1_s3 <= NumW'(mix_s2 * g2_s2);
			b2_s3 <= NumW'(g0_s2 * c1_s2);
			e0_s3 <= NumW'(m2_s2 * g2_s2);
			e1_s3 <= NumW'(mix_s2 * g1_s2);
			e2_s3 <= NumW'(g0_s2 * c0_s2);
		end
	end

	// Stage 4: determinant and negated numerators.
	logic signed [NumW-1:0] det_s4;
	logic signed [NumW-1:0] num_s4 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= d0_s3 + d1_s3 + d2_s3;
			num_s4[0] <= -(a0_s3 + a1_s3 + a2_s3);
			num_s4[1] <= -(b0_s3 + b1_s3 + b2_s3);
			num_s4[2] <= -(e0_s3 + e1_s3 + e2_s3);
		end
	end

	// Stage 5: bit lengths.
	logic signed [NumW-1:0] det_s5;
	logic signed [NumW-1:0] num_s5 [3];
	logic [LenW-1:0] dlen_s5;
	logic [LenW-1:0] nlen_s5 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= det_s4;
			dlen_s5 <= bit_len(det_s4);
			for (int k = 0; k < 3; k++) begin
				num_s5[k] <= num_s4[k];
				nlen_s5[k] <= bit_len(num_s4[k]);
			end
		end
	end

	// Stage 6: saturation and zero tests and common scaling into 32 bits.
	logic signed [DivW-1:0] dvd_s6 [3];
	logic signed [FitW-1:0] dvs_s6 [3];
	res_kind_t kind_s6 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic [LenW-1:0] cb, sh;
				logic signed [NumW-1:0] sn, sd;
				cb = (nlen_s5[k] < dlen_s5) ? dlen_s5 : nlen_s5[k];
				sh = (cb > LenW'(FitW)) ? cb - LenW'(FitW) : '0;
				sn = num_s5[k] >>> sh;
				sd = det_s5 >>> sh;
				dvd_s6[k] <= {sn[FitW-1:0], 12'h000};
				dvs_s6[k] <= sd[FitW-1:0];
				if (det_s5 == '0) begin
					kind_s6[k] <= RES_ZERO;
				end else if ({1'b0, nlen_s5[k]} >= {1'b0, dlen_s5} + (LenW+1)'(SatBits)) begin
					kind_s6[k] <= RES_SAT;
				end else if (sd == '0) begin
					kind_s6[k] <= RES_ZERO;
				end else begin
					kind_s6[k] <= RES_DIV;
				end
			end
		end
	end

	// Divider lanes, one per component.
	out_t q [3];
	res_kind_t kd [3];
	for (genvar k = 0; k < 3; k++) begin : g_lane
		scs_div u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.dividend(dvd_s6[k]), .divisor(dvs_s6[k]), .kind_in(kind_s6[k]),
			.quotient(q[k]), .kind_out(kd[k])
		);
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {5'b0, q[2], q[1], q[0]};
		end
	end

	logic unused_kind;
	assign unused_kind = ^{kd[0], kd[1], kd[2]};
endmodule
`default_nettype wire

// ----- hdl/scs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_checker: port-level checks of the offset solver.
// Watches the stream handshakes over time.
// ----------------------------------------------------------------------------
module scs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata
);
	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled item changed");

	// Input is taken whenever the output is free.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output empty");

	// Fill bits stay zero.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[79:75] == 5'b0)
		else $error("fill bits set");

	// Handshake signals other than m_tready are always known out of reset.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tvalid, s_tready, m_tvalid}))
		else $error("unknown handshake signal");
endmodule

bind symmetric3_cramer_solve_q12 scs_checker u_scs_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
